[hdl/flow_sensor_frame_decoder_assert.svh]
// Assertion macros for the checker file.
`ifndef FLOW_SENSOR_FRAME_DECODER_ASSERT_SVH
`define FLOW_SENSOR_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FSFD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FSFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fsfd_pkg.sv]
package fsfd_pkg;

    localparam int FRAME_BYTES      = 9;
    localparam int DEF_COUNT_BITS   = 32;
    localparam int OUT_COUNT_W      = 32;
    localparam int POS_BITS         = $clog2(FRAME_BYTES + 1);

    // frame byte positions
    localparam int IDX_HDR   = 0;
    localparam int IDX_LEN   = 1;
    localparam int IDX_X_LO  = 2;
    localparam int IDX_X_HI  = 3;
    localparam int IDX_Y_LO  = 4;
    localparam int IDX_Y_HI  = 5;
    localparam int IDX_SUM   = 6;
    localparam int IDX_QUAL  = 7;
    localparam int IDX_END   = 8;

    localparam logic [7:0] HDR_BYTE  = 8'hFE;
    localparam logic [7:0] LEN_BYTE  = 8'h04;
    localparam logic [7:0] END_PLAIN = 8'hAA;
    localparam logic [7:0] END_YAW   = 8'hBB;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        buffer_end;
        logic [31:0] time_now;
    } fsfd_in_t;

    typedef struct packed {
        logic                   frame_valid;
        logic [15:0]            flow_x;
        logic [15:0]            flow_y;
        logic [7:0]             surface_quality;
        logic [31:0]            stamp;
        logic                   yaw_ender_seen;
        logic [OUT_COUNT_W-1:0] good_frames;
        logic [OUT_COUNT_W-1:0] short_buffers;
        logic [OUT_COUNT_W-1:0] buffers_seen;
        logic [OUT_COUNT_W-1:0] bytes_seen;
    } fsfd_out_t;

    typedef struct packed {
        logic ok;
        logic yaw;
    } fsfd_check_t;

endpackage

[hdl/fsfd_frame_check.sv]
module fsfd_frame_check
    import fsfd_pkg::*;
(
    input  logic [7:0]  frame [FRAME_BYTES],
    output fsfd_check_t check
);

    logic [7:0] sum;

    // 8-bit additive checksum over the four data bytes, wraps
    assign sum = frame[IDX_X_LO] + frame[IDX_X_HI] + frame[IDX_Y_LO] + frame[IDX_Y_HI];

    always_comb begin
        check.yaw = (frame[IDX_END] == END_YAW);
        check.ok  = (frame[IDX_HDR] == HDR_BYTE) && (frame[IDX_LEN] == LEN_BYTE) &&
                    (frame[IDX_SUM] == sum) &&
                    ((frame[IDX_END] == END_PLAIN) || (frame[IDX_END] == END_YAW));
    end

endmodule

[hdl/flow_sensor_frame_decoder.sv]
// Channel  | Dir | Handshake         | Payload
// ---------+-----+-------------------+------------------------------------------
// s_       | in  | s_valid / s_ready | fsfd_in_t: one received byte per item
// m_       | out | m_valid / m_ready | fsfd_out_t: one result per buffer end
//
// One byte per cycle is sustained while s_ready is high.
// A buffer-end item has its result registered on the next cycle: in the output
// register, or in the skid while the output register is still held.
// Two result slots (output register plus skid) let input run while m_ready is low;
// s_ready drops only when both slots are full.
// aresetn (synchronous, active low) clears position, held values and counters.
module flow_sensor_frame_decoder
    import fsfd_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  fsfd_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output fsfd_out_t m_data
);

    // buffer position and capture store
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [7:0]          store_reg [FRAME_BYTES];
    logic [7:0]          view      [FRAME_BYTES];

    // held frame values
    logic [15:0] x_reg, x_next;
    logic [15:0] y_reg, y_next;
    logic [7:0]  qual_reg, qual_next;
    logic [31:0] stamp_reg, stamp_next;
    logic        yaw_reg, yaw_next;

    // wrapping counters
    logic [COUNT_BITS-1:0] good_reg, good_next;
    logic [COUNT_BITS-1:0] short_reg, short_next;
    logic [COUNT_BITS-1:0] bufs_reg, bufs_next;
    logic [COUNT_BITS-1:0] bytes_reg, bytes_next;

    // output register plus skid
    logic      out_valid_reg, out_valid_next;
    fsfd_out_t out_reg, out_next;
    logic      skid_valid_reg, skid_valid_next;
    fsfd_out_t skid_reg, skid_next;

    logic        accept;
    logic        capture;
    logic        full_len;
    logic        good;
    logic        push;
    logic        pop;
    fsfd_check_t check;
    fsfd_out_t   result;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign capture = pos_reg < POS_BITS'(FRAME_BYTES);
    // this byte completes the frame, or the frame is already complete
    assign full_len = pos_reg >= POS_BITS'(FRAME_BYTES - 1);

    // store as it stands once this byte is captured
    always_comb begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            view[i] = (pos_reg == POS_BITS'(i)) ? s_data.rx_byte : store_reg[i];
        end
    end

    fsfd_frame_check u_check (
        .frame (view),
        .check (check)
    );

    assign good = s_data.buffer_end && full_len && check.ok;

    always_comb begin
        pos_next   = pos_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        qual_next  = qual_reg;
        stamp_next = stamp_reg;
        yaw_next   = yaw_reg;
        good_next  = good_reg;
        short_next = short_reg;
        bufs_next  = bufs_reg;
        bytes_next = bytes_reg;
        if (accept) begin
            bytes_next = bytes_reg + COUNT_BITS'(1);
            if (capture) begin
                pos_next = pos_reg + POS_BITS'(1);
            end
            if (s_data.buffer_end) begin
                pos_next  = '0;
                bufs_next = bufs_reg + COUNT_BITS'(1);
                if (!full_len) begin
                    short_next = short_reg + COUNT_BITS'(1);
                end else if (check.ok) begin
                    good_next  = good_reg + COUNT_BITS'(1);
                    stamp_next = s_data.time_now;
                    x_next     = {view[IDX_X_HI], view[IDX_X_LO]};
                    y_next     = {view[IDX_Y_HI], view[IDX_Y_LO]};
                    qual_next  = view[IDX_QUAL];
                    if (check.yaw) begin
                        yaw_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        result.frame_valid     = good;
        result.flow_x          = x_next;
        result.flow_y          = y_next;
        result.surface_quality = qual_next;
        result.stamp           = stamp_next;
        result.yaw_ender_seen  = yaw_next;
        result.good_frames     = OUT_COUNT_W'(good_next);
        result.short_buffers   = OUT_COUNT_W'(short_next);
        result.buffers_seen    = OUT_COUNT_W'(bufs_next);
        result.bytes_seen      = OUT_COUNT_W'(bytes_next);
    end

    assign push = accept && s_data.buffer_end;
    assign pop  = out_valid_reg && m_ready;

    // skid can only fill while the output slot is held; it drains first
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            qual_reg       <= '0;
            stamp_reg      <= '0;
            yaw_reg        <= 1'b0;
            good_reg       <= '0;
            short_reg      <= '0;
            bufs_reg       <= '0;
            bytes_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            qual_reg       <= qual_next;
            stamp_reg      <= stamp_next;
            yaw_reg        <= yaw_next;
            good_reg       <= good_next;
            short_reg      <= short_next;
            bufs_reg       <= bufs_next;
            bytes_reg      <= bytes_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (accept && (pos_reg == POS_BITS'(i))) begin
                store_reg[i] <= s_data.rx_byte;
            end
        end
    end

endmodule

[hdl/fsfd_checker.sv]
`include "flow_sensor_frame_decoder_assert.svh"

module fsfd_checker
    import fsfd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input fsfd_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input fsfd_out_t m_data
);

    `FSFD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `FSFD_ASSERT_SAME(a_reset_empty, aclk, aresetn, !$past(aresetn), !m_valid && s_ready, "result slots not empty after reset")
    `FSFD_ASSERT_SAME(a_stall_needs_out, aclk, aresetn, !s_ready, m_valid, "input stalled with no result pending")
    `FSFD_ASSERT_SAME(a_mid_no_result, aclk, aresetn, $past(s_valid && s_ready && !s_data.buffer_end) && !$past(m_valid), !m_valid, "result from a mid-buffer item")

endmodule

bind flow_sensor_frame_decoder fsfd_checker u_fsfd_checker (.*);
